// ===== design/pdc_pkg.sv =====
`default_nettype none

package pdc_pkg;

    // Fixed field widths of the controller.
    localparam int GAIN_W  = 16;
    localparam int DATA_W  = 16;
    localparam int ERR_W   = 18;
    localparam int DERIV_W = 19;
    localparam int CFG_IDX_W = 3;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P     = 3'd0,
        CFG_GAIN_I     = 3'd1,
        CFG_GAIN_D     = 3'd2,
        CFG_SETPOINT   = 3'd3,
        CFG_PWM_PERIOD = 3'd4
    } t_cfg_index;

    // Reset values: Kp = -20.0, Ki = 0.0, Kd = about 0.1 in Q7.8.
    localparam logic [GAIN_W-1:0] GAIN_P_RST     = 16'hEC00;
    localparam logic [GAIN_W-1:0] GAIN_I_RST     = 16'h0000;
    localparam logic [GAIN_W-1:0] GAIN_D_RST     = 16'h001A;
    localparam logic [DATA_W-1:0] SETPOINT_RST   = 16'd40;
    localparam logic [DATA_W-1:0] PWM_PERIOD_RST = 16'd1000;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic [DATA_W-1:0] setpoint;
        logic [DATA_W-1:0] pwm_period;
    } t_cfg;

endpackage

`default_nettype wire

// ===== design/pdc_cfg_regs.sv =====
`default_nettype none

module pdc_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    input  wire logic [pdc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [pdc_pkg::DATA_W-1:0]    i_cfg_data,
    output pdc_pkg::t_cfg                      o_cfg
);
    import pdc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p     <= GAIN_P_RST;
            r_cfg.gain_i     <= GAIN_I_RST;
            r_cfg.gain_d     <= GAIN_D_RST;
            r_cfg.setpoint   <= SETPOINT_RST;
            r_cfg.pwm_period <= PWM_PERIOD_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_GAIN_P:     r_cfg.gain_p     <= i_cfg_data;
                CFG_GAIN_I:     r_cfg.gain_i     <= i_cfg_data;
                CFG_GAIN_D:     r_cfg.gain_d     <= i_cfg_data;
                CFG_SETPOINT:   r_cfg.setpoint   <= i_cfg_data;
                CFG_PWM_PERIOD: r_cfg.pwm_period <= i_cfg_data;
                default: ;  // Unused indexes are dropped.
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== design/pdc_error_stage.sv =====
`default_nettype none

module pdc_error_stage #(
    parameter int SUM_WIDTH = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [pdc_pkg::DATA_W-1:0] i_setpoint,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [pdc_pkg::DATA_W-1:0] i_distance,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic signed [pdc_pkg::ERR_W-1:0]   o_err,
    output logic signed [SUM_WIDTH-1:0]        o_sum,
    output logic signed [pdc_pkg::DERIV_W-1:0] o_deriv
);
    import pdc_pkg::*;

    localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    logic                       r_valid;
    // r_err also serves as the previous error for the next sample.
    logic signed [ERR_W-1:0]    r_err;
    logic signed [SUM_WIDTH-1:0] r_sum;
    logic signed [DERIV_W-1:0]  r_deriv;

    logic                       w_adv;
    logic signed [ERR_W-1:0]    n_err;
    logic signed [SUM_WIDTH:0]  w_sum_wide;
    logic signed [SUM_WIDTH-1:0] n_sum;
    logic signed [DERIV_W-1:0]  n_deriv;

    always_comb begin
        w_adv   = !r_valid || i_ready;
        n_err   = $signed({2'b00, i_setpoint}) - $signed({2'b00, i_distance});
        w_sum_wide = {r_sum[SUM_WIDTH-1], r_sum}
                   + {{(SUM_WIDTH+1-ERR_W){n_err[ERR_W-1]}}, n_err};
        // The integral saturates instead of wrapping.
        if (w_sum_wide[SUM_WIDTH] != w_sum_wide[SUM_WIDTH-1]) begin
            n_sum = w_sum_wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
        end else begin
            n_sum = w_sum_wide[SUM_WIDTH-1:0];
        end
        n_deriv = {n_err[ERR_W-1], n_err} - {r_err[ERR_W-1], r_err};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_err   <= '0;
            r_sum   <= '0;
        end else if (w_adv) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_err <= n_err;
                r_sum <= n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_valid) begin
            r_deriv <= n_deriv;
        end
    end

    assign o_ready = w_adv;
    assign o_valid = r_valid;
    assign o_err   = r_err;
    assign o_sum   = r_sum;
    assign o_deriv = r_deriv;

endmodule

`default_nettype wire

// ===== design/pdc_gain_stage.sv =====
`default_nettype none

module pdc_gain_stage #(
    parameter int SUM_WIDTH = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire pdc_pkg::t_cfg                     i_cfg,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic signed [pdc_pkg::ERR_W-1:0]   i_err,
    input  wire logic signed [SUM_WIDTH-1:0]        i_sum,
    input  wire logic signed [pdc_pkg::DERIV_W-1:0] i_deriv,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic signed [pdc_pkg::GAIN_W+pdc_pkg::ERR_W-1:0]   o_prod_p,
    output logic signed [pdc_pkg::GAIN_W+SUM_WIDTH-1:0]        o_prod_i,
    output logic signed [pdc_pkg::GAIN_W+pdc_pkg::DERIV_W-1:0] o_prod_d
);
    import pdc_pkg::*;

    localparam int PP_W = GAIN_W + ERR_W;
    localparam int PI_W = GAIN_W + SUM_WIDTH;
    localparam int PD_W = GAIN_W + DERIV_W;

    logic                   r_valid;
    logic signed [PP_W-1:0] r_prod_p;
    logic signed [PI_W-1:0] r_prod_i;
    logic signed [PD_W-1:0] r_prod_d;

    logic                   w_adv;
    logic signed [PP_W-1:0] n_prod_p;
    logic signed [PI_W-1:0] n_prod_i;
    logic signed [PD_W-1:0] n_prod_d;

    always_comb begin
        w_adv    = !r_valid || i_ready;
        n_prod_p = $signed(i_cfg.gain_p) * i_err;
        n_prod_i = $signed(i_cfg.gain_i) * i_sum;
        n_prod_d = $signed(i_cfg.gain_d) * i_deriv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_valid) begin
            r_prod_p <= n_prod_p;
            r_prod_i <= n_prod_i;
            r_prod_d <= n_prod_d;
        end
    end

    assign o_ready  = w_adv;
    assign o_valid  = r_valid;
    assign o_prod_p = r_prod_p;
    assign o_prod_i = r_prod_i;
    assign o_prod_d = r_prod_d;

endmodule

`default_nettype wire

// ===== design/pdc_output_stage.sv =====
`default_nettype none

module pdc_output_stage #(
    parameter int GAIN_FRAC_BITS = 8,
    parameter int SUM_WIDTH      = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [pdc_pkg::DATA_W-1:0] i_pwm_period,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic signed [pdc_pkg::GAIN_W+pdc_pkg::ERR_W-1:0]   i_prod_p,
    input  wire logic signed [pdc_pkg::GAIN_W+SUM_WIDTH-1:0]        i_prod_i,
    input  wire logic signed [pdc_pkg::GAIN_W+pdc_pkg::DERIV_W-1:0] i_prod_d,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [pdc_pkg::DATA_W-1:0]      o_duty
);
    import pdc_pkg::*;

    localparam int PP_W  = GAIN_W + ERR_W;
    localparam int PI_W  = GAIN_W + SUM_WIDTH;
    localparam int PD_W  = GAIN_W + DERIV_W;
    localparam int MAX_W = (PI_W > PD_W) ? PI_W : PD_W;
    localparam int ACC_W = MAX_W + 2;
    localparam int Q_W   = ACC_W - GAIN_FRAC_BITS;

    logic              r_valid;
    logic [DATA_W-1:0] r_duty;

    logic              w_adv;
    logic signed [ACC_W-1:0] w_acc;
    logic [Q_W-1:0]    w_quot;
    logic [DATA_W-1:0] w_top;
    logic [DATA_W-1:0] n_duty;

    always_comb begin
        w_adv = !r_valid || !i_stall;
        w_acc = {{(ACC_W-PP_W){i_prod_p[PP_W-1]}}, i_prod_p}
              + {{(ACC_W-PI_W){i_prod_i[PI_W-1]}}, i_prod_i}
              + {{(ACC_W-PD_W){i_prod_d[PD_W-1]}}, i_prod_d};
        w_quot = w_acc[ACC_W-1:GAIN_FRAC_BITS];
        // A zero period behaves like a period of one.
        w_top  = (i_pwm_period == '0) ? '0 : i_pwm_period - 1'b1;
        // A negative sum scales (rounding down) to a value below zero,
        // which clamps to zero, so only the non-negative case needs scaling.
        if (w_acc[ACC_W-1]) begin
            n_duty = '0;
        end else if (w_quot > Q_W'(w_top)) begin
            n_duty = w_top;
        end else begin
            n_duty = w_quot[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_valid) begin
            r_duty <= n_duty;
        end
    end

    assign o_ready = w_adv;
    assign o_valid = r_valid;
    assign o_duty  = r_duty;

endmodule

`default_nettype wire

// ===== design/pid_duty_controller_core.sv =====
// PID duty controller. Each request on the input channel carries one distance
// sample; the block answers with one PWM duty value per sample, in order.
// The input channel uses i_valid with o_stall, the result channel o_valid
// with i_stall; a request moves at a clock edge where valid is high and
// stall is low. Gains, setpoint and PWM period are written through the
// configuration channel (i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data),
// which is always ready; write it only while no sample is in flight.
// The block is a four-register pipeline: input register, error/integral
// register, product register and result register. Each sample passes through
// these registers in order to o_duty; one sample can be taken every cycle while
// o_stall is low. The integral update is a single add-and-saturate, so it
// never holds the pipeline back. When the receiver stalls, stages fill up
// behind the result register and o_stall rises once all four hold a request;
// bubbles are squeezed out first. Synchronous reset empties the pipeline,
// clears the integral and previous error, and loads the default gains
// (Kp -20.0, Ki 0, Kd about 0.1), setpoint 40 and period 1000.
`default_nettype none

module pid_duty_controller_core #(
    parameter int GAIN_FRAC_BITS = 8,
    parameter int SUM_WIDTH      = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Sample input.
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [pdc_pkg::DATA_W-1:0]    i_distance,
    // Duty output.
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [pdc_pkg::DATA_W-1:0]         o_duty,
    // Configuration writes.
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [pdc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [pdc_pkg::DATA_W-1:0]    i_cfg_data
);
    import pdc_pkg::*;

    t_cfg w_cfg;

    // Input register.
    logic              r_in_valid;
    logic [DATA_W-1:0] r_distance;
    logic              w_in_adv;

    // Error stage to gain stage.
    logic                     w_err_ready;
    logic                     w_err_valid;
    logic signed [ERR_W-1:0]     w_err;
    logic signed [SUM_WIDTH-1:0] w_sum;
    logic signed [DERIV_W-1:0]   w_deriv;

    // Gain stage to output stage.
    logic w_gain_ready;
    logic w_gain_valid;
    logic signed [GAIN_W+ERR_W-1:0]     w_prod_p;
    logic signed [GAIN_W+SUM_WIDTH-1:0] w_prod_i;
    logic signed [GAIN_W+DERIV_W-1:0]   w_prod_d;
    logic w_out_ready;

    assign o_cfg_ready = 1'b1;

    pdc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // The input register holds the sample so the error logic
    // sees a registered operand.
    assign w_in_adv = !r_in_valid || w_err_ready;
    assign o_stall  = !w_in_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_adv) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_adv && i_valid) begin
            r_distance <= i_distance;
        end
    end

    // Error, saturating integral and derivative; holds the loop state.
    pdc_error_stage #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_error (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_setpoint (w_cfg.setpoint),
        .i_valid    (r_in_valid),
        .o_ready    (w_err_ready),
        .i_distance (r_distance),
        .o_valid    (w_err_valid),
        .i_ready    (w_gain_ready),
        .o_err      (w_err),
        .o_sum      (w_sum),
        .o_deriv    (w_deriv)
    );

    // Three gain multiplications in parallel, each registered.
    pdc_gain_stage #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_gain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_valid  (w_err_valid),
        .o_ready  (w_gain_ready),
        .i_err    (w_err),
        .i_sum    (w_sum),
        .i_deriv  (w_deriv),
        .o_valid  (w_gain_valid),
        .i_ready  (w_out_ready),
        .o_prod_p (w_prod_p),
        .o_prod_i (w_prod_i),
        .o_prod_d (w_prod_d)
    );

    // Sum of terms, fixed-point scaling and clamp into the result register.
    pdc_output_stage #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .SUM_WIDTH      (SUM_WIDTH)
    ) u_output (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pwm_period (w_cfg.pwm_period),
        .i_valid      (w_gain_valid),
        .o_ready      (w_out_ready),
        .i_prod_p     (w_prod_p),
        .i_prod_i     (w_prod_i),
        .i_prod_d     (w_prod_d),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_duty       (o_duty)
    );

endmodule

`default_nettype wire
